### sv/pls_pkg.sv
// ----------------------------------------------------------------------------
// pls_pkg
// Types and codes shared by the positional list store and its cells.
// ----------------------------------------------------------------------------
package pls_pkg;

   localparam int POS_W  = 7;
   localparam int DATA_W = 32;

   typedef enum logic [1:0] {
      FUNC_INSERT   = 2'd0,
      FUNC_DELETE   = 2'd1,
      FUNC_UPDATE   = 2'd2,
      FUNC_RETRIEVE = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_BADPOS = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   // per-edge command broadcast along the cell row
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_UPDATE,
      CELL_READ,
      CELL_CLEAR
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type             cmd;
      logic [POS_W-1:0]         at;
      logic signed [DATA_W-1:0] data;
   } cell_ctl_type;

   typedef struct packed {
      func_type                 func;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] item;
   } req_type;

   typedef struct packed {
      status_type               status;
      logic signed [DATA_W-1:0] read_data;
      logic [POS_W-1:0]         length;
      logic                     is_empty;
   } rsp_type;

endpackage

### sv/pls_cell.sv
// ----------------------------------------------------------------------------
// pls_cell
// One list entry: holds, shifts from a neighbor, is written or is read.
// ----------------------------------------------------------------------------
module pls_cell
   import pls_pkg::*;
#(
   parameter int unsigned INDEX = 0
) (
   input  logic                     clock,
   input  cell_ctl_type             ctl,
   input  logic signed [DATA_W-1:0] left_value,
   input  logic signed [DATA_W-1:0] right_value,
   output logic signed [DATA_W-1:0] value,
   output logic signed [DATA_W-1:0] read_value
);

   logic signed [DATA_W-1:0] value_ff, value_in;
   logic signed [DATA_W-1:0] rd_ff, rd_in;
   logic                     hit, below_at, from_at;

   assign hit      = (32'(ctl.at) == INDEX);
   assign below_at = (INDEX < 32'(ctl.at));
   assign from_at  = !below_at;

   always_comb begin
      value_in = value_ff;
      rd_in    = rd_ff;
      case (ctl.cmd)
         CELL_HOLD: begin
         end
         CELL_INSERT: begin
            // open the gap: entries above the slot move up
            if (hit) begin
               value_in = ctl.data;
            end else if (from_at) begin
               value_in = left_value;
            end
            rd_in = '0;
         end
         CELL_DELETE: begin
            // close the gap
            if (from_at) begin
               value_in = right_value;
            end
            rd_in = '0;
         end
         CELL_UPDATE: begin
            if (hit) begin
               value_in = ctl.data;
            end
            rd_in = '0;
         end
         CELL_READ: begin
            rd_in = hit ? value_ff : '0;
         end
         CELL_CLEAR: begin
            rd_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      rd_ff    <= rd_in;
   end

   assign value      = value_ff;
   assign read_value = rd_ff;

endmodule

### sv/pls_ctrl.sv
// ----------------------------------------------------------------------------
// pls_ctrl
// Request decode, position checks and the entry count.
// ----------------------------------------------------------------------------
module pls_ctrl
   import pls_pkg::*;
#(
   parameter int CAPACITY = 64,
   parameter int CNT_W    = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  req_type          req,
   input  logic             accept,
   output cell_ctl_type     ctl,
   output status_type       status,
   output logic [CNT_W-1:0] count_next
);

   localparam int CW = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CW-1:0]    pos_x, cnt_x;
   logic             pos_zero;

   assign pos_x    = CW'(req.position);
   assign cnt_x    = CW'(count_ff);
   assign pos_zero = (req.position == '0);

   always_comb begin
      status   = ST_OK;
      count_in = count_ff;
      ctl.cmd  = CELL_HOLD;
      ctl.at   = req.position - POS_W'(1);
      ctl.data = req.item;
      if (req.func == FUNC_INSERT) begin
         if (pos_zero || (pos_x > cnt_x + CW'(1))) begin
            status = ST_BADPOS;
         end else if (cnt_x >= CW'(CAPACITY)) begin
            status = ST_FULL;
         end else begin
            ctl.cmd  = CELL_INSERT;
            count_in = count_ff + CNT_W'(1);
         end
      end else if (count_ff == '0) begin
         status = ST_EMPTY;
      end else if (pos_zero || (pos_x > cnt_x)) begin
         status = ST_BADPOS;
      end else begin
         case (req.func)
            FUNC_DELETE: begin
               ctl.cmd  = CELL_DELETE;
               count_in = count_ff - CNT_W'(1);
            end
            FUNC_UPDATE:   ctl.cmd = CELL_UPDATE;
            FUNC_RETRIEVE: ctl.cmd = CELL_READ;
            default:       ctl.cmd = CELL_HOLD;
         endcase
      end
      // a failed request still clears stale read data in the cells
      if (status != ST_OK) begin
         ctl.cmd = CELL_CLEAR;
      end
      if (!accept) begin
         ctl.cmd  = CELL_HOLD;
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign count_next = count_in;

endmodule

### sv/positional_list_store.sv
// ----------------------------------------------------------------------------
// positional_list_store
// Ordered list of signed 32-bit values addressed by 1-based position.
// ----------------------------------------------------------------------------
// The list lives in a row of CAPACITY cells, one entry per cell. Each request
// (insert, delete, update, retrieve) is decoded against the entry count and
// broadcast to every cell; on insert the slot cell takes the new item and the
// cells above it take their lower neighbor, on delete the cells at and above
// the slot take their upper neighbor, so any operation updates the whole row
// at once. A retrieve latches the addressed entry in that cell's read
// register; when the middle stage advances, the OR of all cells' read
// registers goes into the response register. One item is taken every cycle
// while req_stall is low. An item waits in the middle stage while the output
// register is full and rsp_stall is high, and req_stall rises only when both
// stages are full. Entries come up undefined and are never read before an
// insert writes them; the count is cleared by reset.
// ----------------------------------------------------------------------------
module positional_list_store
   import pls_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   cell_ctl_type     ctl;
   status_type       status;
   logic [CNT_W-1:0] count_next;
   logic             accept, rsp_load;

   logic signed [DATA_W-1:0] cell_value [CAPACITY];
   logic signed [DATA_W-1:0] cell_read  [CAPACITY];
   logic signed [DATA_W-1:0] read_or;

   // middle stage: status and count wait here while the cells hold read data
   logic             s1_valid_ff, s1_valid_in;
   status_type       s1_status_ff;
   logic [POS_W-1:0] s1_len_ff;
   logic             s1_empty_ff;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff;

   // advance the middle stage when the output register is free or drains
   assign rsp_load  = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !rsp_load;
   assign accept    = req_valid && !req_stall;

   pls_ctrl #(
      .CAPACITY (CAPACITY),
      .CNT_W    (CNT_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req        (req_payload),
      .accept     (accept),
      .ctl        (ctl),
      .status     (status),
      .count_next (count_next)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [DATA_W-1:0] left_v, right_v;
      if (i == 0) begin : g_first
         assign left_v = '0;
      end else begin : g_mid_l
         assign left_v = cell_value[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_v = '0;
      end else begin : g_mid_r
         assign right_v = cell_value[i+1];
      end
      pls_cell #(
         .INDEX (i)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .left_value  (left_v),
         .right_value (right_v),
         .value       (cell_value[i]),
         .read_value  (cell_read[i])
      );
   end

   // at most one cell holds a nonzero read value
   always_comb begin
      read_or = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         read_or = read_or | cell_read[i];
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (rsp_load) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold payload until the stage advances
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_status_ff <= status;
         s1_len_ff    <= POS_W'(count_next);
         s1_empty_ff  <= (count_next == '0);
      end
      if (rsp_load) begin
         rsp_ff.status    <= s1_status_ff;
         rsp_ff.read_data <= read_or;
         rsp_ff.length    <= s1_len_ff;
         rsp_ff.is_empty  <= s1_empty_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

### test/tb_positional_list_store.sv
// ----------------------------------------------------------------------------
// tb_positional_list_store
// Self-checking bench for the positional list store.
// ----------------------------------------------------------------------------
// A shadow list in the bench tracks every accepted request and predicts the
// status, read data, length and empty flag. The checking process compares
// each response against the oldest prediction. The stimulus has four parts:
// a directed walk over the edge cases, a fill to capacity and a drain, a long
// receiver hold-off while requests keep coming, and random traffic in segments
// that lean toward growing or shrinking the list. Both sides insert random
// idle cycles, and some segments run with no idling at all.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_positional_list_store;
   import pls_pkg::*;

   localparam int CAPACITY    = 64;
   localparam int GAP_MAX     = 17;
   localparam int HOLD_CYCLES = 300;
   localparam int SEGMENTS    = 16;
   localparam int SEG_ITEMS   = 85;
   localparam int DRAIN_WAIT  = 20;
   localparam int CYCLE_LIMIT = 400000;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;

   // Shadow copy of the list, advanced once per accepted item.
   logic signed [DATA_W-1:0] list_mem [CAPACITY];
   int                       list_count;
   rsp_type                  expected_rsp_q [$];

   // Idle control shared by the tests and the receiver.
   bit req_no_idle      = 1'b0;
   bit rsp_no_idle      = 1'b0;
   int hold_off_request = 0;

   // Bookkeeping for the closing summary.
   int fail_count  = 0;
   int items_sent  = 0;
   int peak_length = 0;
   int status_seen [4] = '{default: 0};
   int cycle_count = 0;

   positional_list_store #(
      .CAPACITY (CAPACITY)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Abort on a hang: a lost response or a stuck stall ends up here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Apply one request to the shadow list and return the response it causes.
   function automatic rsp_type apply_list_op(req_type r);
      rsp_type res;
      int      pos;
      res           = '0;
      res.status    = ST_OK;
      res.read_data = '0;
      pos           = int'(r.position);
      if (r.func == FUNC_INSERT) begin
         if (pos < 1 || pos > list_count + 1) begin
            res.status = ST_BADPOS;
         end else if (list_count >= CAPACITY) begin
            res.status = ST_FULL;
         end else begin
            // open a slot: entries at and above the position move up by one
            for (int i = list_count; i > pos - 1; i--) list_mem[i] = list_mem[i-1];
            list_mem[pos-1] = r.item;
            list_count++;
         end
      end else if (list_count == 0) begin
         res.status = ST_EMPTY;
      end else if (pos < 1 || pos > list_count) begin
         res.status = ST_BADPOS;
      end else begin
         case (r.func)
            FUNC_DELETE: begin
               // close the gap
               for (int i = pos - 1; i < list_count - 1; i++) list_mem[i] = list_mem[i+1];
               list_count--;
            end
            FUNC_UPDATE:   list_mem[pos-1] = r.item;
            FUNC_RETRIEVE: res.read_data = list_mem[pos-1];
            default: ;
         endcase
      end
      res.length   = 7'(list_count);
      res.is_empty = (list_count == 0);
      return res;
   endfunction

   // Offer one item after a random idle gap and hold it until accepted.
   // The prediction is made at the accepting edge, so list_count always
   // reflects every item the block has taken.
   task automatic send_request(input func_type f, input int pos,
                               input logic signed [DATA_W-1:0] val);
      req_type r;
      int      gap;
      r.func     = f;
      r.position = 7'(pos);
      r.item     = val;
      gap = req_no_idle ? 0 : $urandom_range(0, GAP_MAX);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_rsp_q.push_back(apply_list_op(r));
      items_sent++;
   endtask

   // Mostly a legal position for the operation, sometimes anything at all.
   function automatic int pick_position(func_type f);
      int top;
      top = (f == FUNC_INSERT) ? list_count + 1 : list_count;
      if (top == 0 || $urandom_range(0, 99) < 12) return $urandom_range(0, 127);
      return $urandom_range(1, top);
   endfunction

   // Random data with the sign boundaries and all-zero/all-one mixed in.
   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 39))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // Receiver: stall for a drawn number of cycles, then take one item.
   // A pending hold-off request replaces the draw with a long stall.
   initial begin : rsp_receiver
      int n;
      forever begin
         if (hold_off_request > 0) begin
            n                = hold_off_request;
            hold_off_request = 0;
         end else begin
            n = rsp_no_idle ? 0 : $urandom_range(0, GAP_MAX);
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            for (int k = 0; k < n; k++) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // Compare every accepted response with the oldest prediction.
   always @(posedge clock) begin : check_rsp
      rsp_type exp_rsp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp_q.size() == 0) begin
            $error("unexpected item: status %0d read_data %0d length %0d is_empty %0d",
                   rsp_payload.status, rsp_payload.read_data, rsp_payload.length,
                   rsp_payload.is_empty);
            fail_count++;
         end else begin
            exp_rsp = expected_rsp_q.pop_front();
            if (rsp_payload.status !== exp_rsp.status) begin
               $error("status: expected %0d, actual %0d", exp_rsp.status, rsp_payload.status);
               fail_count++;
            end
            if (rsp_payload.read_data !== exp_rsp.read_data) begin
               $error("read_data: expected %0d, actual %0d",
                      exp_rsp.read_data, rsp_payload.read_data);
               fail_count++;
            end
            if (rsp_payload.length !== exp_rsp.length) begin
               $error("length: expected %0d, actual %0d", exp_rsp.length, rsp_payload.length);
               fail_count++;
            end
            if (rsp_payload.is_empty !== exp_rsp.is_empty) begin
               $error("is_empty: expected %0d, actual %0d",
                      exp_rsp.is_empty, rsp_payload.is_empty);
               fail_count++;
            end
            status_seen[int'(exp_rsp.status)]++;
            if (int'(exp_rsp.length) > peak_length) peak_length = int'(exp_rsp.length);
         end
      end
   end

   // Empty-list handling, bad positions on both sides of the range, inserts
   // at front, middle and end, and extreme data through update and retrieve.
   task automatic test_edge_cases();
      // empty list wins over a bad position
      send_request(FUNC_RETRIEVE, 1, 32'sd5);
      send_request(FUNC_DELETE, 0, '1);
      send_request(FUNC_UPDATE, 127, '1);
      send_request(FUNC_INSERT, 0, 32'sd1);
      send_request(FUNC_INSERT, 2, 32'sd1);
      send_request(FUNC_INSERT, 127, 32'sd1);
      send_request(FUNC_INSERT, 1, 32'sh8000_0000);
      send_request(FUNC_INSERT, 2, 32'sh7fff_ffff);
      send_request(FUNC_INSERT, 1, '0);
      send_request(FUNC_INSERT, 2, 32'sh5555_5555);
      for (int p = 1; p <= 4; p++) send_request(FUNC_RETRIEVE, p, '1);
      send_request(FUNC_RETRIEVE, 0, '0);
      send_request(FUNC_RETRIEVE, 5, '0);
      send_request(FUNC_RETRIEVE, 127, '0);
      send_request(FUNC_UPDATE, 4, 32'shaaaa_aaaa);
      send_request(FUNC_RETRIEVE, 4, '0);
      send_request(FUNC_UPDATE, 5, '1);
      send_request(FUNC_DELETE, 2, '1);
      send_request(FUNC_RETRIEVE, 2, '0);
      send_request(FUNC_DELETE, 4, '0);
      // drain to empty to see the flag come back
      repeat (3) send_request(FUNC_DELETE, 1, '0);
   endtask

   // Fill at random legal positions, probe the full store, read every
   // entry back, then drain at random positions.
   task automatic test_fill_to_capacity();
      while (list_count < CAPACITY) begin
         send_request(FUNC_INSERT, $urandom_range(1, list_count + 1), pick_value());
      end
      send_request(FUNC_INSERT, CAPACITY + 1, 32'sd7);
      send_request(FUNC_INSERT, 1, 32'sd7);
      // bad position is reported ahead of full
      send_request(FUNC_INSERT, CAPACITY + 2, 32'sd7);
      send_request(FUNC_INSERT, 0, 32'sd7);
      send_request(FUNC_UPDATE, CAPACITY, 32'sh7fff_ffff);
      send_request(FUNC_RETRIEVE, CAPACITY + 1, '0);
      send_request(FUNC_DELETE, CAPACITY + 1, '0);
      for (int p = 1; p <= CAPACITY; p++) send_request(FUNC_RETRIEVE, p, $urandom);
      while (list_count > 0) begin
         send_request(FUNC_DELETE, $urandom_range(1, list_count), $urandom);
      end
   endtask

   // Hold the receiver off for a long stretch while requests keep arriving
   // back to back, so the block fills and pushes back on its input.
   task automatic test_back_pressure();
      req_no_idle      = 1'b1;
      hold_off_request = HOLD_CYCLES;
      for (int n = 0; n < 40; n++) begin
         send_request((n < 30) ? FUNC_INSERT : FUNC_RETRIEVE,
                      pick_position((n < 30) ? FUNC_INSERT : FUNC_RETRIEVE), pick_value());
      end
      req_no_idle = 1'b0;
   endtask

   // Random traffic in segments: each leans toward growth, shrinkage or
   // balance, and picks its own idling on each side.
   task automatic test_random_traffic();
      int       ins_pct;
      func_type f;
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         case ($urandom_range(0, 2))
            0:       ins_pct = 75;
            1:       ins_pct = 15;
            default: ins_pct = 40;
         endcase
         req_no_idle = ($urandom_range(0, 3) == 0);
         rsp_no_idle = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < SEG_ITEMS; n++) begin
            if ($urandom_range(0, 99) < ins_pct) f = FUNC_INSERT;
            else f = func_type'($urandom_range(1, 3));
            send_request(f, pick_position(f), pick_value());
         end
      end
      req_no_idle = 1'b0;
      rsp_no_idle = 1'b0;
   endtask

   initial begin : main_sequence
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      list_count  = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_edge_cases();
      test_fill_to_capacity();
      test_back_pressure();
      test_random_traffic();
      // drop valid at the step the last item was taken
      req_valid <= 1'b0;

      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Covered %0d items: ok %0d, empty %0d, bad position %0d, full %0d",
               items_sent, status_seen[ST_OK], status_seen[ST_EMPTY],
               status_seen[ST_BADPOS], status_seen[ST_FULL]);
      $display("Peak list length %0d of %0d, %0d mismatches",
               peak_length, CAPACITY, fail_count);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
